// File: hw/rtl/pcsa_pkg.sv
// Shared constants, types and saturation helpers for the point stiffness assembly block.
`default_nettype none

package pcsa_pkg;

    // Block sizing
    localparam int MAX_NODES = 8;
    localparam int NODE_BITS = 20;
    localparam int FRAC_BITS = 16;

    // Fixed data widths
    localparam int DATA_W  = 32;              // Q16.16 signed values
    localparam int PARAM_W = 31;              // conductivity and volume
    localparam int SUM_W   = 48;              // potential gradient sums
    localparam int PROD_W  = 2 * DATA_W;      // full product
    localparam int WIDE_W  = PROD_W + 1;      // headroom for adds before saturation
    localparam int ACC_W   = DATA_W + 2;      // sum of up to three saturated terms
    localparam int NUM_DIMS = 3;
    localparam int DIM_W    = 2;
    localparam logic [DIM_W-1:0] LAST_DIM = DIM_W'(NUM_DIMS - 1);
    localparam logic [DIM_W-1:0] DIMS_RESET = DIM_W'(3);

    // Node counters
    localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CNT_W = $clog2(MAX_NODES + 1);

    // Stream packing
    localparam int IN_BITS     = NODE_BITS + 4 * DATA_W + 2 * PARAM_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = 2 * NODE_BITS + 5 * DATA_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Saturation bounds in the wide domain
    localparam logic signed [WIDE_W-1:0] S32_HI =
        {{(WIDE_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
    localparam logic signed [WIDE_W-1:0] S32_LO =
        {{(WIDE_W - DATA_W + 1){1'b1}}, {(DATA_W - 1){1'b0}}};
    localparam logic signed [WIDE_W-1:0] S48_HI =
        {{(WIDE_W - SUM_W + 1){1'b0}}, {(SUM_W - 1){1'b1}}};
    localparam logic signed [WIDE_W-1:0] S48_LO =
        {{(WIDE_W - SUM_W + 1){1'b1}}, {(SUM_W - 1){1'b0}}};

    // Multiplier results: floor-shifted product and its 32-bit saturation
    typedef struct packed {
        logic signed [DATA_W-1:0] q;
        logic signed [PROD_W-1:0] shifted;
    } mul_res_t;

    function automatic logic signed [DATA_W-1:0] sat_s32(input logic signed [WIDE_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > S32_HI)
            r = {1'b0, {(DATA_W - 1){1'b1}}};
        else if (v < S32_LO)
            r = {1'b1, {(DATA_W - 1){1'b0}}};
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

    function automatic logic signed [SUM_W-1:0] sat_s48(input logic signed [WIDE_W-1:0] v);
        logic signed [SUM_W-1:0] r;
        if (v > S48_HI)
            r = {1'b0, {(SUM_W - 1){1'b1}}};
        else if (v < S48_LO)
            r = {1'b1, {(SUM_W - 1){1'b0}}};
        else
            r = v[SUM_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/point_conductance_stiffness_assembly.sv
// Top level: node loading, gradient and flux, and stiffness triple sequencer.
//
// A material point arrives as a run of node beats on the slave stream, the last one marked
// by s_tlast, and leaves as one triple beat per (row, column) node pair, row-major, with
// m_tlast on the final pair. Everything runs through one registered 32x32 multiplier, each
// product issued and then shifted, saturated and accumulated, under a one-hot sequencer,
// and s_tready is high only while the sequencer is idle. A stored node beat is accepted
// and then takes three gradient products; a beat past the node limit is only accepted.
// The closing beat adds the flux, then each row computes its load term and each triple
// its stiffness term, and the master side can hold the block by keeping m_tready low.
// Node data sits in an 8-row memory with two registered read ports, one for the row node
// and one for the column node. The finished triple waits in an output register, so the
// next point can start loading while it waits.
`default_nettype none

module point_conductance_stiffness_assembly (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // configuration: active_dims
    input  wire logic                                  cfg_we,
    input  wire logic [pcsa_pkg::DIM_W-1:0]            cfg_wdata,
    // node beats
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // node_index, grad_shape_x, grad_shape_y, grad_shape_z, node_potential,
    // conductivity, point_volume, zero pad
    input  wire logic [pcsa_pkg::IN_TDATA_W-1:0]       s_tdata,
    input  wire logic                                  s_tlast,     // last_node
    // triple beats
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // row_node, col_node, stiffness, load_value, grad_x, grad_y, grad_z
    output logic [pcsa_pkg::OUT_TDATA_W-1:0]           m_tdata,
    output logic [0:0]                                 m_tuser,     // load_valid
    output logic                                       m_tlast      // last_entry
);
    import pcsa_pkg::*;

    // Input field offsets
    localparam int IN_GX  = NODE_BITS;
    localparam int IN_GY  = IN_GX + DATA_W;
    localparam int IN_GZ  = IN_GY + DATA_W;
    localparam int IN_PHI = IN_GZ + DATA_W;
    localparam int IN_CND = IN_PHI + DATA_W;
    localparam int IN_VOL = IN_CND + PARAM_W;

    typedef struct packed {
        logic        [NODE_BITS-1:0] id;
        logic signed [DATA_W-1:0]    gz;
        logic signed [DATA_W-1:0]    gy;
        logic signed [DATA_W-1:0]    gx;
    } row_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]    gz;
        logic signed [DATA_W-1:0]    gy;
        logic signed [DATA_W-1:0]    gx;
        logic signed [DATA_W-1:0]    load_value;
        logic signed [DATA_W-1:0]    stiffness;
        logic        [NODE_BITS-1:0] col;
        logic        [NODE_BITS-1:0] row;
    } out_t;

    typedef enum logic [16:0] {
        S_IDLE   = 17'b1 << 0,
        S_GMUL   = 17'b1 << 1,
        S_GACC   = 17'b1 << 2,
        S_FMUL   = 17'b1 << 3,
        S_FACC   = 17'b1 << 4,
        S_RFETCH = 17'b1 << 5,
        S_LMUL   = 17'b1 << 6,
        S_LACC   = 17'b1 << 7,
        S_LVMUL  = 17'b1 << 8,
        S_LVACC  = 17'b1 << 9,
        S_KFETCH = 17'b1 << 10,
        S_KMUL   = 17'b1 << 11,
        S_KACC   = 17'b1 << 12,
        S_KCMUL  = 17'b1 << 13,
        S_KCACC  = 17'b1 << 14,
        S_KVMUL  = 17'b1 << 15,
        S_EMIT   = 17'b1 << 16
    } state_t;

    function automatic logic signed [DATA_W-1:0] dim_pick(input row_t r,
                                                          input logic [DIM_W-1:0] d);
        logic signed [DATA_W-1:0] v;
        case (d)
            2'd0:    v = r.gx;
            2'd1:    v = r.gy;
            default: v = r.gz;
        endcase
        return v;
    endfunction

    // Control registers
    state_t               state_reg, state_next;
    logic [DIM_W-1:0]     dims_reg, dims_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [DIM_W-1:0]     d_reg, d_next;
    logic [IDX_W-1:0]     a_reg, a_next;
    logic [IDX_W-1:0]     b_reg, b_next;
    logic                 out_valid_reg, out_valid_next;
    logic signed [SUM_W-1:0] sum_reg [NUM_DIMS];
    logic signed [SUM_W-1:0] sum_next [NUM_DIMS];

    // Payload registers
    logic signed [DATA_W-1:0]  g_reg [NUM_DIMS];
    logic signed [DATA_W-1:0]  g_next [NUM_DIMS];
    logic signed [DATA_W-1:0]  phi_reg, phi_next;
    logic        [PARAM_W-1:0] cond_reg, cond_next;
    logic        [PARAM_W-1:0] vol_reg, vol_next;
    logic                      last_reg, last_next;
    logic signed [DATA_W-1:0]  flux_reg [NUM_DIMS];
    logic signed [DATA_W-1:0]  flux_next [NUM_DIMS];
    logic signed [DATA_W-1:0]  grad_reg [NUM_DIMS];
    logic signed [DATA_W-1:0]  grad_next [NUM_DIMS];
    logic signed [ACC_W-1:0]   lsum_reg, lsum_next;
    logic signed [ACC_W-1:0]   ksum_reg, ksum_next;
    logic signed [DATA_W-1:0]  load_reg, load_next;
    logic signed [DATA_W-1:0]  k_reg, k_next;
    out_t                      out_reg, out_next;
    logic                      out_load_valid_reg, out_load_valid_next;
    logic                      out_last_reg, out_last_next;

    // Node memory
    row_t                      node_mem [MAX_NODES];
    row_t                      rd_a_reg, rd_b_reg;
    row_t                      wr_row;
    logic                      mem_we;

    // Multiplier
    logic                      mul_en;
    logic signed [DATA_W-1:0]  op_a, op_b;
    mul_res_t                  mres;

    logic                      in_accept;
    logic                      out_free;
    logic                      can_store;
    logic                      d_done;
    logic                      a_last, b_last;
    logic signed [DATA_W-1:0]  grad_sat;

    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign can_store = (count_reg < CNT_W'(MAX_NODES));
    assign d_done    = (DIM_W'(d_reg + DIM_W'(1)) == dims_reg);
    assign a_last    = (CNT_W'(a_reg) + CNT_W'(1) == count_reg);
    assign b_last    = (CNT_W'(b_reg) + CNT_W'(1) == count_reg);
    assign grad_sat  = sat_s32(WIDE_W'(sum_reg[d_reg]));

    assign wr_row.id = s_tdata[NODE_BITS-1:0];
    assign wr_row.gx = s_tdata[IN_GX +: DATA_W];
    assign wr_row.gy = s_tdata[IN_GY +: DATA_W];
    assign wr_row.gz = s_tdata[IN_GZ +: DATA_W];
    assign mem_we    = in_accept && can_store;

    // Node memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            node_mem[count_reg[IDX_W-1:0]] <= wr_row;
        end
        rd_a_reg <= node_mem[a_reg];
        rd_b_reg <= node_mem[b_reg];
    end

    // Operand selection for the shared multiplier
    always_comb
    begin
        mul_en = 1'b1;
        op_a   = '0;
        op_b   = '0;
        case (state_reg)
            S_GMUL:
            begin
                op_a = g_reg[d_reg];
                op_b = phi_reg;
            end
            S_FMUL:
            begin
                op_a = $signed({1'b0, cond_reg});
                op_b = grad_sat;
            end
            S_LMUL:
            begin
                op_a = dim_pick(rd_a_reg, d_reg);
                op_b = flux_reg[d_reg];
            end
            S_LVMUL:
            begin
                op_a = sat_s32(WIDE_W'(lsum_reg));
                op_b = $signed({1'b0, vol_reg});
            end
            S_KMUL:
            begin
                op_a = dim_pick(rd_a_reg, d_reg);
                op_b = dim_pick(rd_b_reg, d_reg);
            end
            S_KCMUL:
            begin
                op_a = sat_s32(WIDE_W'(ksum_reg));
                op_b = $signed({1'b0, cond_reg});
            end
            S_KVMUL:
            begin
                op_a = k_reg;
                op_b = $signed({1'b0, vol_reg});
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    pcsa_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .op_a (op_a),
        .op_b (op_b),
        .res  (mres)
    );

    // Sequencer
    always_comb
    begin
        state_next          = state_reg;
        dims_next           = dims_reg;
        count_next          = count_reg;
        d_next              = d_reg;
        a_next              = a_reg;
        b_next              = b_reg;
        sum_next            = sum_reg;
        g_next              = g_reg;
        phi_next            = phi_reg;
        cond_next           = cond_reg;
        vol_next            = vol_reg;
        last_next           = last_reg;
        flux_next           = flux_reg;
        grad_next           = grad_reg;
        lsum_next           = lsum_reg;
        ksum_next           = ksum_reg;
        load_next           = load_reg;
        k_next              = k_reg;
        out_next            = out_reg;
        out_load_valid_next = out_load_valid_reg;
        out_last_next       = out_last_reg;
        out_valid_next      = out_valid_reg && !m_tready;

        if (cfg_we)
        begin
            dims_next = cfg_wdata;
        end

        case (state_reg)
            // take a node beat
            S_IDLE:
            begin
                if (in_accept)
                begin
                    g_next[0] = wr_row.gx;
                    g_next[1] = wr_row.gy;
                    g_next[2] = wr_row.gz;
                    phi_next  = s_tdata[IN_PHI +: DATA_W];
                    cond_next = s_tdata[IN_CND +: PARAM_W];
                    vol_next  = s_tdata[IN_VOL +: PARAM_W];
                    last_next = s_tlast;
                    d_next    = '0;
                    if (can_store)
                    begin
                        count_next = count_reg + CNT_W'(1);
                        state_next = S_GMUL;
                    end
                    else if (s_tlast)
                    begin
                        state_next = S_FMUL;
                    end
                end
            end
            S_GMUL:
            begin
                state_next = S_GACC;
            end
            // add gradient term to its 48-bit sum
            S_GACC:
            begin
                sum_next[d_reg] = sat_s48(WIDE_W'(sum_reg[d_reg]) + WIDE_W'(mres.shifted));
                if (d_reg == LAST_DIM)
                begin
                    d_next     = '0;
                    state_next = last_reg ? S_FMUL : S_IDLE;
                end
                else
                begin
                    d_next     = d_reg + DIM_W'(1);
                    state_next = S_GMUL;
                end
            end
            S_FMUL:
            begin
                state_next = S_FACC;
            end
            // gradient and flux per dimension
            S_FACC:
            begin
                flux_next[d_reg] = mres.q;
                grad_next[d_reg] = grad_sat;
                if (d_reg == LAST_DIM)
                begin
                    a_next     = '0;
                    b_next     = '0;
                    state_next = S_RFETCH;
                end
                else
                begin
                    d_next     = d_reg + DIM_W'(1);
                    state_next = S_FMUL;
                end
            end
            // row load term
            S_RFETCH:
            begin
                d_next     = '0;
                lsum_next  = '0;
                state_next = (dims_reg == '0) ? S_LVMUL : S_LMUL;
            end
            S_LMUL:
            begin
                state_next = S_LACC;
            end
            S_LACC:
            begin
                lsum_next = lsum_reg + ACC_W'(mres.q);
                if (d_done)
                begin
                    state_next = S_LVMUL;
                end
                else
                begin
                    d_next     = d_reg + DIM_W'(1);
                    state_next = S_LMUL;
                end
            end
            S_LVMUL:
            begin
                state_next = S_LVACC;
            end
            S_LVACC:
            begin
                load_next  = mres.q;
                b_next     = '0;
                state_next = S_KFETCH;
            end
            // stiffness term for one pair
            S_KFETCH:
            begin
                d_next     = '0;
                ksum_next  = '0;
                state_next = (dims_reg == '0) ? S_KCMUL : S_KMUL;
            end
            S_KMUL:
            begin
                state_next = S_KACC;
            end
            S_KACC:
            begin
                ksum_next = ksum_reg + ACC_W'(mres.q);
                if (d_done)
                begin
                    state_next = S_KCMUL;
                end
                else
                begin
                    d_next     = d_reg + DIM_W'(1);
                    state_next = S_KMUL;
                end
            end
            S_KCMUL:
            begin
                state_next = S_KCACC;
            end
            S_KCACC:
            begin
                k_next     = mres.q;
                state_next = S_KVMUL;
            end
            S_KVMUL:
            begin
                state_next = S_EMIT;
            end
            // hand the triple to the output register
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    out_next.row         = rd_a_reg.id;
                    out_next.col         = rd_b_reg.id;
                    out_next.stiffness   = mres.q;
                    out_load_valid_next  = (b_reg == '0);
                    out_last_next        = a_last && b_last;
                    if (b_reg == '0)
                    begin
                        out_next.load_value = load_reg;
                        out_next.gx         = grad_reg[0];
                        out_next.gy         = grad_reg[1];
                        out_next.gz         = grad_reg[2];
                    end
                    else
                    begin
                        out_next.load_value = '0;
                        out_next.gx         = '0;
                        out_next.gy         = '0;
                        out_next.gz         = '0;
                    end
                    if (b_last)
                    begin
                        if (a_last)
                        begin
                            count_next = '0;
                            for (int i = 0; i < NUM_DIMS; i++)
                            begin
                                sum_next[i] = '0;
                            end
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            a_next     = a_reg + IDX_W'(1);
                            state_next = S_RFETCH;
                        end
                    end
                    else
                    begin
                        b_next     = b_reg + IDX_W'(1);
                        state_next = S_KFETCH;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            dims_reg      <= DIMS_RESET;
            count_reg     <= '0;
            d_reg         <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_DIMS; i++)
            begin
                sum_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            dims_reg      <= dims_next;
            count_reg     <= count_next;
            d_reg         <= d_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            out_valid_reg <= out_valid_next;
            sum_reg       <= sum_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        g_reg              <= g_next;
        phi_reg            <= phi_next;
        cond_reg           <= cond_next;
        vol_reg            <= vol_next;
        last_reg           <= last_next;
        flux_reg           <= flux_next;
        grad_reg           <= grad_next;
        lsum_reg           <= lsum_next;
        ksum_reg           <= ksum_next;
        load_reg           <= load_next;
        k_reg              <= k_next;
        out_reg            <= out_next;
        out_load_valid_reg <= out_load_valid_next;
        out_last_reg       <= out_last_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(out_reg);
    assign m_tuser  = out_load_valid_reg;
    assign m_tlast  = out_last_reg;

    // A node beat past the limit leaves the count alone
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && count_reg == CNT_W'(MAX_NODES)) |=> (count_reg == CNT_W'(MAX_NODES)))
        else $error("count moved on a beat past the node limit");

    // A handed-off triple shows up on the master side
    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && out_free) |=> m_tvalid)
        else $error("triple lost between sequencer and output register");

    // The final pair closes the point and clears the count
    a_point_close: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && out_free && a_last && b_last)
        |=> (state_reg == S_IDLE && count_reg == '0 && m_tlast))
        else $error("point not closed after its final triple");

    // Gradient accumulation only follows a stored node
    a_gacc_stored: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GACC) |-> (count_reg != '0))
        else $error("gradient term accumulated with no stored node");

endmodule

`default_nettype wire

// File: hw/rtl/pcsa_mul.sv
// Shared registered 32x32 signed multiplier with Q16.16 floor shift and saturation.
`default_nettype none

module pcsa_mul (
    input  wire logic                                clk,
    input  wire logic                                en,
    input  wire logic signed [pcsa_pkg::DATA_W-1:0]  op_a,
    input  wire logic signed [pcsa_pkg::DATA_W-1:0]  op_b,
    output pcsa_pkg::mul_res_t                       res
);
    import pcsa_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] shifted;

    // Product register, loaded only when an operation is issued
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= op_a * op_b;
        end
    end

    // Arithmetic shift rounds toward minus infinity
    assign shifted     = prod_reg >>> FRAC_BITS;
    assign res.shifted = shifted;
    assign res.q       = sat_s32(WIDE_W'(shifted));

endmodule

`default_nettype wire

// File: test/tb_top.sv
// Self-checking testbench for point_conductance_stiffness_assembly: node stream in, triples out.
`timescale 1ns / 100ps

module tb_top;
    import pcsa_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PRINT_CAP     = 100;
    localparam int RANDOM_BEATS  = 460;
    localparam int PHASES        = 8;

    localparam logic signed [DATA_W-1:0] QTOP  = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] QBOT  = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] ONE_Q = 32'sh0001_0000;
    localparam logic [PARAM_W-1:0]       PTOP  = {PARAM_W{1'b1}};
    localparam logic [PARAM_W-1:0]       ONE_P = PARAM_W'(32'h0001_0000);

    localparam longint Q_MAX   = 64'sd2147483647;
    localparam longint Q_MIN   = -64'sd2147483648;
    localparam longint SUM_MAX = 64'sd140737488355327;
    localparam longint SUM_MIN = -64'sd140737488355328;

    typedef struct {
        logic [NODE_BITS-1:0]     node;
        logic signed [DATA_W-1:0] gsx, gsy, gsz, phi;
        logic [PARAM_W-1:0]       cond, vol;
        logic                     last;
    } node_beat_t;

    typedef struct {
        logic [NODE_BITS-1:0]     row, col;
        logic signed [DATA_W-1:0] stiff;
        logic                     load_valid;
        logic signed [DATA_W-1:0] load, gx, gy, gz;
        logic                     last;
    } triple_t;

    // DUT ports
    logic                    clk;
    logic                    rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [DIM_W-1:0]        cfg_wdata = '0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata = '0;
    logic                    s_tlast = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic [0:0]              m_tuser;
    logic                    m_tlast;

    // Stimulus and scoreboard
    node_beat_t node_beats [$];
    node_beat_t beat_on_bus;
    triple_t    pending_triples [$];
    int         idle_pct = 0;
    int         stall_pct = 0;
    int         error_count = 0;
    int         cycle_count = 0;

    // Model state of the block
    logic [DIM_W-1:0]     dims_model = DIMS_RESET;
    logic [NODE_BITS-1:0] held_node [MAX_NODES];
    longint               held_grad [MAX_NODES][NUM_DIMS];
    longint               grad_sum [NUM_DIMS] = '{default: 0};
    int                   held_count = 0;
    longint               cond_latch = 0;
    longint               vol_latch = 0;

    point_conductance_stiffness_assembly DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint clamp(longint v, longint lo, longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic longint sat32(longint v);
        return clamp(v, Q_MIN, Q_MAX);
    endfunction

    // Q16.16 product, floor shift, 32-bit saturation
    function automatic longint qmul(longint a, longint b);
        return sat32((a * b) >>> FRAC_BITS);
    endfunction

    // Fold one accepted node beat into the point; on the closing beat expand all triples
    function automatic void absorb_node(node_beat_t nb);
        longint  grad [NUM_DIMS];
        longint  flux [NUM_DIMS];
        longint  lsum, ksum, load, stiff;
        triple_t t;
        cond_latch = longint'(nb.cond);
        vol_latch  = longint'(nb.vol);
        // beats past the node limit only latch conductivity and volume
        if (held_count < MAX_NODES)
        begin
            held_node[held_count]    = nb.node;
            held_grad[held_count][0] = nb.gsx;
            held_grad[held_count][1] = nb.gsy;
            held_grad[held_count][2] = nb.gsz;
            for (int d = 0; d < NUM_DIMS; d++)
                grad_sum[d] = clamp(grad_sum[d] +
                    ((held_grad[held_count][d] * longint'(nb.phi)) >>> FRAC_BITS),
                    SUM_MIN, SUM_MAX);
            held_count++;
        end
        if (!nb.last)
            return;

        for (int d = 0; d < NUM_DIMS; d++)
        begin
            grad[d] = sat32(grad_sum[d]);
            flux[d] = qmul(cond_latch, grad[d]);
        end
        // row-major triples; the first column carries load and gradient
        for (int a = 0; a < held_count; a++)
        begin
            lsum = 0;
            for (int d = 0; d < dims_model; d++)
                lsum += qmul(held_grad[a][d], flux[d]);
            load = qmul(sat32(lsum), vol_latch);
            for (int b = 0; b < held_count; b++)
            begin
                ksum = 0;
                for (int d = 0; d < dims_model; d++)
                    ksum += qmul(held_grad[a][d], held_grad[b][d]);
                stiff = qmul(qmul(sat32(ksum), cond_latch), vol_latch);
                t.row        = held_node[a];
                t.col        = held_node[b];
                t.stiff      = DATA_W'(stiff);
                t.load_valid = (b == 0);
                t.load       = (b == 0) ? DATA_W'(load) : '0;
                t.gx         = (b == 0) ? DATA_W'(grad[0]) : '0;
                t.gy         = (b == 0) ? DATA_W'(grad[1]) : '0;
                t.gz         = (b == 0) ? DATA_W'(grad[2]) : '0;
                t.last       = (a == held_count - 1) && (b == held_count - 1);
                pending_triples.push_back(t);
            end
        end
        held_count = 0;
        for (int d = 0; d < NUM_DIMS; d++)
            grad_sum[d] = 0;
    endfunction

    function automatic void check_field(string name, logic [DATA_W-1:0] want_v,
                                        logic [DATA_W-1:0] got_v);
        if (want_v !== got_v)
        begin
            error_count++;
            if (error_count <= PRINT_CAP)
                $display("%0t: %s mismatch: expected %h, actual %h",
                         $time, name, want_v, got_v);
        end
    endfunction

    // Compare the triple on the bus against the oldest expectation
    function automatic void check_triple();
        triple_t want;
        if (pending_triples.size() == 0)
        begin
            error_count++;
            if (error_count <= PRINT_CAP)
                $display("%0t: triple beat with nothing expected: expected none, actual %h",
                         $time, m_tdata);
            return;
        end
        want = pending_triples.pop_front();
        check_field("row_node", want.row, m_tdata[NODE_BITS-1:0]);
        check_field("col_node", want.col, m_tdata[NODE_BITS +: NODE_BITS]);
        check_field("stiffness", want.stiff, m_tdata[2*NODE_BITS +: DATA_W]);
        check_field("load_valid", want.load_valid, m_tuser[0]);
        check_field("load_value", want.load, m_tdata[2*NODE_BITS + DATA_W +: DATA_W]);
        check_field("grad_x", want.gx, m_tdata[2*NODE_BITS + 2*DATA_W +: DATA_W]);
        check_field("grad_y", want.gy, m_tdata[2*NODE_BITS + 3*DATA_W +: DATA_W]);
        check_field("grad_z", want.gz, m_tdata[2*NODE_BITS + 4*DATA_W +: DATA_W]);
        check_field("last_entry", want.last, m_tlast);
    endfunction

    // Random Q16.16 value: mostly small, some full range, some corners
    function automatic logic signed [DATA_W-1:0] pick_q();
        int r;
        logic signed [DATA_W-1:0] m;
        r = $urandom_range(99);
        if (r < 55)
        begin
            m = $urandom_range(0, 262144);
            return $urandom_range(1) ? -m : m;
        end
        if (r < 85)
            return $urandom;
        case ($urandom_range(5))
            0:       return QTOP;
            1:       return QBOT;
            2:       return '0;
            3:       return '1;
            4:       return ONE_Q;
            default: return -ONE_Q;
        endcase
    endfunction

    function automatic logic [PARAM_W-1:0] pick_param();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return PARAM_W'($urandom_range(0, 262144));
        if (r < 85)
            return PARAM_W'($urandom);
        case ($urandom_range(3))
            0:       return '0;
            1:       return PTOP;
            2:       return ONE_P;
            default: return PARAM_W'(1);
        endcase
    endfunction

    function automatic logic [NODE_BITS-1:0] pick_node();
        if ($urandom_range(99) < 90)
            return NODE_BITS'($urandom);
        return $urandom_range(1) ? '1 : '0;
    endfunction

    function automatic void push_beat(input logic [NODE_BITS-1:0] node,
                                      input logic signed [DATA_W-1:0] gsx, gsy, gsz, phi,
                                      input logic [PARAM_W-1:0] cond, vol,
                                      input logic last);
        node_beat_t nb;
        nb.node = node;
        nb.gsx  = gsx;
        nb.gsy  = gsy;
        nb.gsz  = gsz;
        nb.phi  = phi;
        nb.cond = cond;
        nb.vol  = vol;
        nb.last = last;
        node_beats.push_back(nb);
    endfunction

    // One point of random nodes; vary gives each beat its own conductivity and volume
    function automatic void queue_point(int nodes, bit vary);
        logic [PARAM_W-1:0] c, v;
        c = pick_param();
        v = pick_param();
        for (int i = 0; i < nodes; i++)
            push_beat(pick_node(), pick_q(), pick_q(), pick_q(), pick_q(),
                      vary ? pick_param() : c, vary ? pick_param() : v, i == nodes - 1);
    endfunction

    // Block idle: all beats taken, all triples seen, then let it settle
    task automatic wait_idle();
        do
            @(negedge clk);
        while (node_beats.size() != 0 || s_tvalid || pending_triples.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_dims(input logic [DIM_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        dims_model = value;
    endtask

    // Node beat driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tlast  <= 1'b0;
            s_tdata  <= '0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (s_tvalid)
                absorb_node(beat_on_bus);
            if (node_beats.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                beat_on_bus = node_beats.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= IN_TDATA_W'({beat_on_bus.vol, beat_on_bus.cond,
                                         beat_on_bus.phi, beat_on_bus.gsz,
                                         beat_on_bus.gsy, beat_on_bus.gsx,
                                         beat_on_bus.node});
                s_tlast  <= beat_on_bus.last;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Triple monitor with random back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
                check_triple();
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // Test sequence
    initial
    begin
        int queued;
        int nodes;
        int r;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed points at the reset dimension count, no idling
        push_beat('1, QTOP, QTOP, QTOP, QTOP, PTOP, PTOP, 1'b1);
        push_beat('0, QBOT, QBOT, QBOT, QBOT, '0, '0, 1'b1);
        // eight nodes driving the gradient sums into positive saturation
        for (int i = 0; i < MAX_NODES; i++)
            push_beat(NODE_BITS'(i * 1000 + 5), QBOT, QBOT, QBOT, QBOT, ONE_P, ONE_P,
                      i == MAX_NODES - 1);
        // negative saturation of the sums
        for (int i = 0; i < 3; i++)
            push_beat(NODE_BITS'(i + 77), QTOP, QTOP, QTOP, QBOT, ONE_P, PTOP, i == 2);
        // too many nodes, changing conductivity and volume on every beat
        queue_point(MAX_NODES + 2, 1'b1);
        push_beat('0, ONE_Q, -ONE_Q, 32'sh0000_8000, 32'sh0002_0000, ONE_P, ONE_P, 1'b0);
        push_beat('1, -ONE_Q, ONE_Q, 32'sh0000_0001, -32'sh0000_8000, 31'h3_0000,
                  31'h0_8000, 1'b1);
        wait_idle();

        // random phases across dimension counts and idle patterns
        for (int p = 0; p < PHASES; p++)
        begin
            write_dims(DIM_W'((p * 3 + 1) % 4));
            case (p % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 47; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 47; end
                default: begin idle_pct = 12; stall_pct = 12; end
            endcase
            queued = 0;
            while (queued < RANDOM_BEATS / PHASES)
            begin
                r = $urandom_range(99);
                if (r < 12)
                    nodes = $urandom_range(MAX_NODES + 1, MAX_NODES + 3);
                else if (r < 50)
                    nodes = $urandom_range(1, 3);
                else
                    nodes = $urandom_range(4, MAX_NODES);
                queue_point(nodes, $urandom_range(9) < 2);
                queued += nodes;
            end
            wait_idle();
        end

        if (error_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
